>>> design/great_circle_distance_unit_macros.svh
// ----------------------------------------------------------------------------
// Great-circle distance unit: assertion macros
// Concurrent checks that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_DISTANCE_UNIT_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define GCD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define GCD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define GCD_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define GCD_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

>>> design/gcd_pkg.sv
// ----------------------------------------------------------------------------
// Great-circle distance package
// Field widths, Q60 constants, pipeline latencies and the CORDIC angle function.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int LAT_W    = 31;
  localparam int LON_W    = 32;
  localparam int ANG_W    = 33;
  localparam int ACC_W    = 27;
  localparam int DLT_W    = 28;
  localparam int DIST_W   = 31;
  localparam int RAD_W    = 23;
  localparam int RAD100_W = 30;

  typedef logic signed [63:0] q60_t;

  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam q60_t        ONE_Q60 = 64'sh1000000000000000;
  localparam q60_t        K_Q60   = 64'sd700114967498147786;

  localparam logic signed [34:0] FULL_TURN    = 35'sd3600000000;
  localparam logic signed [34:0] HALF_TURN    = 35'sd1800000000;
  localparam logic signed [34:0] QUARTER_TURN = 35'sd900000000;

  // pi in Q60 per 1e-7 degree, split into quotient and remainder
  localparam logic [63:0] PI_DIV_HALF = PI_Q60 / 64'd1800000000;
  localparam logic [63:0] PI_MOD_HALF = PI_Q60 % 64'd1800000000;
  // reciprocal of a half turn scaled by 2^59
  localparam logic [63:0] RECIP_HALF  = (64'd1 << 59) / 64'd1800000000;

  localparam logic [RAD100_W-1:0] RAD100_RESET = 30'd637101000;

  localparam int MUL_LAT    = 5;
  localparam int PREP_LAT   = 5;
  localparam int SQRT_STEPS = 32;

  function automatic longint pw(int i, int m);
    int e;
    e = i * m;
    if (e > 60) return 64'sd0;
    return longint'(64'd1 << (60 - e));
  endfunction

  // atan(2^-i) in Q60 from the truncated series
  function automatic q60_t atan_q60(int i);
    longint s;
    s = 0;
    if (i == 0) return q60_t'(PI_Q60 >> 2);
    s = pw(i, 1)       - pw(i, 3) / 3   + pw(i, 5) / 5   - pw(i, 7) / 7
      + pw(i, 9) / 9   - pw(i, 11) / 11 + pw(i, 13) / 13 - pw(i, 15) / 15
      + pw(i, 17) / 17 - pw(i, 19) / 19 + pw(i, 21) / 21 - pw(i, 23) / 23
      + pw(i, 25) / 25 - pw(i, 27) / 27 + pw(i, 29) / 29 - pw(i, 31) / 31
      + pw(i, 33) / 33 - pw(i, 35) / 35 + pw(i, 37) / 37 - pw(i, 39) / 39
      + pw(i, 41) / 41 - pw(i, 43) / 43 + pw(i, 45) / 45 - pw(i, 47) / 47
      + pw(i, 49) / 49 - pw(i, 51) / 51 + pw(i, 53) / 53 - pw(i, 55) / 55
      + pw(i, 57) / 57 - pw(i, 59) / 59;
    return q60_t'(s);
  endfunction

endpackage

>>> design/great_circle_distance_unit.sv
// ----------------------------------------------------------------------------
// Great-circle distance unit
// Spherical law of cosines between two points, fully pipelined CORDIC.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) takes a pair of points: latitude and
// longitude in 1e-7 degree, accuracy in cm and a valid bit for each point.
// Output channel (out_valid / out_stall) returns status, distance in cm and
// the summed accuracy in cm, one result item for every input item, in order.
// The cfg port writes the earth radius in metres; cfg_ready is high whenever
// the block is out of reset.
// From input to out_valid an item passes three sine/cosine rows of
// CORDIC_STEPS cells, a 32-cell square root row, a vectoring row and
// five-stage Q60 multipliers between them. Throughput is one item per
// cycle while no result waits under out_stall.
// The whole pipeline advances together; while a result waits under
// out_stall the pipeline holds and in_stall is raised, otherwise an item is
// taken every cycle. Reset clears all valid bits and loads a radius of
// 6371010 m; in_stall is high during reset, so no item is taken then.
// ----------------------------------------------------------------------------
`include "great_circle_distance_unit_macros.svh"

module great_circle_distance_unit #(
  parameter int CORDIC_STEPS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [gcd_pkg::LAT_W-1:0]   in_src_lat,
  input  logic signed [gcd_pkg::LON_W-1:0]   in_src_lon,
  input  logic        [gcd_pkg::ACC_W-1:0]   in_src_accuracy,
  input  logic                               in_src_valid,
  input  logic signed [gcd_pkg::LAT_W-1:0]   in_tar_lat,
  input  logic signed [gcd_pkg::LON_W-1:0]   in_tar_lon,
  input  logic        [gcd_pkg::ACC_W-1:0]   in_tar_accuracy,
  input  logic                               in_tar_valid,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic        [gcd_pkg::RAD_W-1:0]   cfg_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_status,
  output logic        [gcd_pkg::DIST_W-1:0]  out_distance_cm,
  output logic        [gcd_pkg::DLT_W-1:0]   out_delta_cm
);
  import gcd_pkg::*;

  localparam int LAT_SC = PREP_LAT + CORDIC_STEPS + MUL_LAT + 1;
  localparam int L_MID  = LAT_SC + 2 * MUL_LAT + 1 + SQRT_STEPS + CORDIC_STEPS + 1
                        + MUL_LAT;

  typedef struct packed {
    logic             vld;
    logic             err;
    logic             same;
    logic [DLT_W-1:0] delta;
  } side_t;

  logic adv;
  logic out_valid_r;

  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv || !rst_n;
  assign cfg_ready = rst_n;

  // radius register, kept pre-scaled to centimetres
  logic [RAD100_W-1:0] rad100_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad100_r <= RAD100_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rad100_r <= RAD100_W'(cfg_data) * RAD100_W'(100);
    end
  end

  // input stage
  side_t                  side_nxt, side_r;
  logic signed [LAT_W-1:0] slat_r, tlat_r;
  logic signed [ANG_W-1:0] dlon_r;

  always_comb begin
    side_nxt.vld   = in_valid;
    side_nxt.err   = !(in_src_valid && in_tar_valid);
    side_nxt.same  = (in_src_lat == in_tar_lat) && (in_src_lon == in_tar_lon);
    side_nxt.delta = side_nxt.err ? '0
                   : DLT_W'(in_src_accuracy) + DLT_W'(in_tar_accuracy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (adv) begin
      side_r <= side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      slat_r <= in_src_lat;
      tlat_r <= in_tar_lat;
      dlon_r <= ANG_W'(in_tar_lon) - ANG_W'(in_src_lon);
    end
  end

  // sine and cosine of both latitudes and of the longitude difference
  q60_t ca, sa, cb, sb, cd, sd;

  gcd_sincos #(.N(CORDIC_STEPS)) u_sc_a (
    .clk(clk), .rst_n(rst_n), .en(adv), .ang(ANG_W'(slat_r)), .cos_q(ca), .sin_q(sa)
  );
  gcd_sincos #(.N(CORDIC_STEPS)) u_sc_b (
    .clk(clk), .rst_n(rst_n), .en(adv), .ang(ANG_W'(tlat_r)), .cos_q(cb), .sin_q(sb)
  );
  gcd_sincos #(.N(CORDIC_STEPS)) u_sc_d (
    .clk(clk), .rst_n(rst_n), .en(adv), .ang(dlon_r), .cos_q(cd), .sin_q(sd)
  );

  // cos alpha = sa*sb + (ca*cb)*cd, clamped to [-1,1]
  q60_t        pab, pcc, p3, cd_d, pab_d, csum, c_r;
  logic [63:0] cd_dv, pab_dv, sd_unused;

  assign sd_unused = sd;

  gcd_mul u_mab (.clk(clk), .en(adv), .a(sa), .b(sb), .p(pab));
  gcd_mul u_mcc (.clk(clk), .en(adv), .a(ca), .b(cb), .p(pcc));

  gcd_delay #(.W(64), .DEPTH(MUL_LAT)) u_dcd (
    .clk(clk), .rst_n(rst_n), .en(adv), .d(cd), .q(cd_dv)
  );
  assign cd_d = q60_t'(cd_dv);

  gcd_mul u_mc3 (.clk(clk), .en(adv), .a(pcc), .b(cd_d), .p(p3));

  gcd_delay #(.W(64), .DEPTH(MUL_LAT)) u_dab (
    .clk(clk), .rst_n(rst_n), .en(adv), .d(pab), .q(pab_dv)
  );
  assign pab_d = q60_t'(pab_dv);
  assign csum  = pab_d + p3;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (csum > ONE_Q60) begin
        c_r <= ONE_Q60;
      end else if (csum < -ONE_Q60) begin
        c_r <= -ONE_Q60;
      end else begin
        c_r <= csum;
      end
    end
  end

  // square roots of 1+c and 1-c
  logic [63:0] sqv_p [SQRT_STEPS+1];
  logic [63:0] sqr_p [SQRT_STEPS+1];
  logic [63:0] sqv_m [SQRT_STEPS+1];
  logic [63:0] sqr_m [SQRT_STEPS+1];

  assign sqv_p[0] = 64'(ONE_Q60 + c_r);
  assign sqv_m[0] = 64'(ONE_Q60 - c_r);
  assign sqr_p[0] = '0;
  assign sqr_m[0] = '0;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    gcd_sqrt_cell #(.IDX(g)) u_sq_p (
      .clk(clk), .en(adv), .v_in(sqv_p[g]), .r_in(sqr_p[g]),
      .v_out(sqv_p[g+1]), .r_out(sqr_p[g+1])
    );
    gcd_sqrt_cell #(.IDX(g)) u_sq_m (
      .clk(clk), .en(adv), .v_in(sqv_m[g]), .r_in(sqr_m[g]),
      .v_out(sqv_m[g+1]), .r_out(sqr_m[g+1])
    );
  end

  // acos = 2 * atan2(sqrt(1-c), sqrt(1+c)) by vectoring
  q60_t vx_w [CORDIC_STEPS+1];
  q60_t vy_w [CORDIC_STEPS+1];
  q60_t vz_w [CORDIC_STEPS+1];

  assign vx_w[0] = q60_t'({sqr_p[SQRT_STEPS][33:0], 30'd0});
  assign vy_w[0] = q60_t'({sqr_m[SQRT_STEPS][33:0], 30'd0});
  assign vz_w[0] = '0;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
    gcd_cordic_cell #(.IDX(g), .VEC(1'b1)) u_cell (
      .clk  (clk),
      .en   (adv),
      .x_in (vx_w[g]),
      .y_in (vy_w[g]),
      .z_in (vz_w[g]),
      .x_out(vx_w[g+1]),
      .y_out(vy_w[g+1]),
      .z_out(vz_w[g+1])
    );
  end

  q60_t a2, alpha_r, pdist;

  assign a2 = vz_w[CORDIC_STEPS] <<< 1;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (a2[63]) begin
        alpha_r <= '0;
      end else if (a2 > q60_t'(PI_Q60)) begin
        alpha_r <= q60_t'(PI_Q60);
      end else begin
        alpha_r <= a2;
      end
    end
  end

  gcd_mul u_mdist (
    .clk(clk), .en(adv), .a(alpha_r), .b(q60_t'({34'd0, rad100_r})), .p(pdist)
  );

  // side data travels alongside the datapath
  logic [$bits(side_t)-1:0] side_dv;
  side_t                    side_d;

  gcd_delay #(.W($bits(side_t)), .DEPTH(L_MID)) u_dside (
    .clk(clk), .rst_n(rst_n), .en(adv), .d(side_r), .q(side_dv)
  );
  assign side_d = side_t'(side_dv);

  // output register
  logic [DIST_W-1:0] dist_sat;
  logic              out_status_r;
  logic [DIST_W-1:0] out_dist_r;
  logic [DLT_W-1:0]  out_delta_r;

  assign dist_sat = (|pdist[63:DIST_W]) ? '1 : pdist[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= side_d.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= side_d.err;
      out_dist_r   <= (side_d.err || side_d.same) ? '0 : dist_sat;
      out_delta_r  <= side_d.delta;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_distance_cm = out_dist_r;
  assign out_delta_cm    = out_delta_r;

  `GCD_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_status, out_distance_cm == '0 && out_delta_cm == '0)
  `GCD_ASSERT_NXT(a_cfg_write, clk, rst_n, cfg_valid && cfg_ready, rad100_r == RAD100_W'($past(cfg_data)) * RAD100_W'(100))
  `GCD_ASSERT_IMP(a_hold_blocks, clk, rst_n, out_valid && out_stall, in_stall)

endmodule

>>> design/gcd_delay.sv
// ----------------------------------------------------------------------------
// Delay line
// Fixed-depth register chain that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
module gcd_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) tap_r[i] <= '0;
    end else if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

>>> design/gcd_mul.sv
// ----------------------------------------------------------------------------
// Q60 multiplier
// Signed Q60 product, rounded half away from zero, in five pipeline stages
// built from four 32x32 partial products.
// ----------------------------------------------------------------------------
module gcd_mul (
  input  logic          clk,
  input  logic          en,
  input  gcd_pkg::q60_t a,
  input  gcd_pkg::q60_t b,
  output gcd_pkg::q60_t p
);
  import gcd_pkg::*;

  logic [63:0]  ua_r, ub_r;
  logic [63:0]  ll_r, lh_r, hl_r, hh_r;
  logic [127:0] sum_r;
  logic [62:0]  mag_r;
  logic [3:0]   ng_r;
  logic [69:0]  rnd;
  q60_t         p_r;

  assign rnd = {1'b0, sum_r[127:59]} + 70'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      ua_r  <= a[63] ? 64'(-a) : 64'(a);
      ub_r  <= b[63] ? 64'(-b) : 64'(b);
      ng_r  <= {ng_r[2:0], a[63] ^ b[63]};
      ll_r  <= 64'(ua_r[31:0]) * 64'(ub_r[31:0]);
      lh_r  <= 64'(ua_r[31:0]) * 64'(ub_r[63:32]);
      hl_r  <= 64'(ua_r[63:32]) * 64'(ub_r[31:0]);
      hh_r  <= 64'(ua_r[63:32]) * 64'(ub_r[63:32]);
      sum_r <= {64'd0, ll_r} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0}
             + {hh_r, 64'd0};
      mag_r <= rnd[63:1];
      p_r   <= ng_r[3] ? -q60_t'({1'b0, mag_r}) : q60_t'({1'b0, mag_r});
    end
  end

  assign p = p_r;

endmodule

>>> design/gcd_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One micro-rotation step in rotation or vectoring mode, registered.
// ----------------------------------------------------------------------------
module gcd_cordic_cell #(
  parameter int IDX = 0,
  parameter bit VEC = 1'b0
) (
  input  logic          clk,
  input  logic          en,
  input  gcd_pkg::q60_t x_in,
  input  gcd_pkg::q60_t y_in,
  input  gcd_pkg::q60_t z_in,
  output gcd_pkg::q60_t x_out,
  output gcd_pkg::q60_t y_out,
  output gcd_pkg::q60_t z_out
);
  import gcd_pkg::*;

  localparam q60_t ANGLE = atan_q60(IDX);

  q60_t dx, dy;
  q60_t x_nxt, y_nxt, z_nxt;
  q60_t x_r, y_r, z_r;
  logic up;

  assign dx = y_in >>> IDX;
  assign dy = x_in >>> IDX;
  // vectoring drives y to zero, rotation drives z to zero
  assign up = VEC ? !y_in[63] : z_in[63];

  always_comb begin
    if (up) begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + ANGLE;
    end else begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule

>>> design/gcd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One result bit of the digit-by-digit integer square root, registered.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell #(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] v_in,
  input  logic [63:0] r_in,
  output logic [63:0] v_out,
  output logic [63:0] r_out
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * IDX);

  logic [63:0] t;
  logic [63:0] v_r, r_r;

  assign t = r_in + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (v_in >= t) begin
        v_r <= v_in - t;
        r_r <= (r_in >> 1) + BIT;
      end else begin
        v_r <= v_in;
        r_r <= r_in >> 1;
      end
    end
  end

  assign v_out = v_r;
  assign r_out = r_r;

endmodule

>>> design/gcd_sincos.sv
// ----------------------------------------------------------------------------
// Sine and cosine
// Reduces an angle in 1e-7 degree to Q60 radians, runs it down a row of
// rotation cells and folds the leftover angle in with two multiplies.
// ----------------------------------------------------------------------------
module gcd_sincos #(
  parameter int N = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic signed [gcd_pkg::ANG_W-1:0] ang,
  output gcd_pkg::q60_t                    cos_q,
  output gcd_pkg::q60_t                    sin_q
);
  import gcd_pkg::*;

  localparam logic [33:0] H1 = 34'(HALF_TURN);
  localparam logic [33:0] H2 = 34'(2 * HALF_TURN);
  localparam logic [33:0] H3 = 34'(3 * HALF_TURN);

  // stage 1: wrap into [-180,180) and fold to within a quarter turn
  logic signed [34:0] r0, r1, r2;
  logic               ng1_nxt;
  logic [29:0]        m_nxt;

  always_comb begin
    r0 = 35'(ang);
    r1 = r0;
    if (r0 >= HALF_TURN) begin
      r1 = r0 - FULL_TURN;
    end else if (r0 < -HALF_TURN) begin
      r1 = r0 + FULL_TURN;
    end
    r2 = r1;
    ng1_nxt = 1'b0;
    if (r1 > QUARTER_TURN) begin
      r2 = r1 - HALF_TURN;
      ng1_nxt = 1'b1;
    end else if (r1 < -QUARTER_TURN) begin
      r2 = r1 + HALF_TURN;
      ng1_nxt = 1'b1;
    end
    m_nxt = r2[34] ? 30'(-r2) : 30'(r2);
  end

  logic [29:0] m1_r;
  logic [4:0]  sg_r, ng_r;
  logic [58:0] prem2_r;
  logic [60:0] mq2_r, mq3_r, mq4_r;
  logic [59:0] v3_r;
  logic [61:0] pr3_r;
  logic [29:0] qe4_r;
  logic [33:0] rem4_r;
  q60_t        z5_r;

  logic [59:0] v_nxt;
  logic [29:0] qe;
  logic [59:0] rem_full;
  logic [1:0]  corr;
  logic [60:0] rad;

  assign v_nxt    = 60'(prem2_r) + 60'(QUARTER_TURN);
  assign qe       = pr3_r[61:32];
  assign rem_full = v3_r - 60'(qe) * 60'(HALF_TURN);
  assign corr     = 2'(rem4_r >= H1) + 2'(rem4_r >= H2) + 2'(rem4_r >= H3);
  assign rad      = mq4_r + 61'(qe4_r) + 61'(corr);

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r    <= m_nxt;
      sg_r    <= {sg_r[3:0], r2[34]};
      ng_r    <= {ng_r[3:0], ng1_nxt};
      prem2_r <= 59'(m1_r) * 59'(PI_MOD_HALF);
      mq2_r   <= 61'(m1_r) * 61'(PI_DIV_HALF);
      v3_r    <= v_nxt;
      pr3_r   <= 62'(v_nxt[59:27]) * 62'(RECIP_HALF);
      mq3_r   <= mq2_r;
      qe4_r   <= qe;
      rem4_r  <= rem_full[33:0];
      mq4_r   <= mq3_r;
      z5_r    <= sg_r[3] ? -q60_t'(rad) : q60_t'(rad);
    end
  end

  // rotation row
  q60_t x_w [N+1];
  q60_t y_w [N+1];
  q60_t z_w [N+1];

  assign x_w[0] = K_Q60;
  assign y_w[0] = '0;
  assign z_w[0] = z5_r;

  for (genvar g = 0; g < N; g++) begin : g_rot
    gcd_cordic_cell #(.IDX(g), .VEC(1'b0)) u_cell (
      .clk  (clk),
      .en   (en),
      .x_in (x_w[g]),
      .y_in (y_w[g]),
      .z_in (z_w[g]),
      .x_out(x_w[g+1]),
      .y_out(y_w[g+1]),
      .z_out(z_w[g+1])
    );
  end

  // fold the leftover angle in
  q60_t pzy, pzx, xd, yd, xf, yf;
  logic [127:0] xy_d;
  logic         ng_d;
  q60_t         cos_r, sin_r;

  gcd_mul u_mzy (.clk(clk), .en(en), .a(z_w[N]), .b(y_w[N]), .p(pzy));
  gcd_mul u_mzx (.clk(clk), .en(en), .a(z_w[N]), .b(x_w[N]), .p(pzx));

  gcd_delay #(.W(128), .DEPTH(MUL_LAT)) u_dxy (
    .clk(clk), .rst_n(rst_n), .en(en), .d({x_w[N], y_w[N]}), .q(xy_d)
  );

  gcd_delay #(.W(1), .DEPTH(N + MUL_LAT)) u_dng (
    .clk(clk), .rst_n(rst_n), .en(en), .d(ng_r[4]), .q(ng_d)
  );

  assign xd = q60_t'(xy_d[127:64]);
  assign yd = q60_t'(xy_d[63:0]);
  assign xf = xd - pzy;
  assign yf = yd + pzx;

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= ng_d ? -xf : xf;
      sin_r <= ng_d ? -yf : yf;
    end
  end

  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// Great-circle distance unit testbench
// Walks a table of directed point pairs, then random pairs over several
// radius settings and idling mixes. Every result item is checked field by
// field against a fixed-point predictor of the law-of-cosines distance.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import gcd_pkg::*;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_ARG_ERR = 1'b1;
  localparam int   PIPE_WAIT      = 140;
  localparam int   WDOG_LIMIT     = 5000;
  localparam int   HOLD_CYCLES    = 400;
  localparam longint L90  = 900000000;
  localparam longint L180 = 1800000000;
  localparam longint L360 = 64'sd3600000000;
  localparam longint AMAX = 100000000;

  typedef struct packed {
    logic signed [LAT_W-1:0] slat;
    logic signed [LON_W-1:0] slon;
    logic [ACC_W-1:0]        sacc;
    logic                    sval;
    logic signed [LAT_W-1:0] tlat;
    logic signed [LON_W-1:0] tlon;
    logic [ACC_W-1:0]        tacc;
    logic                    tval;
    logic                    typed;
    logic                    st;
    logic [DIST_W-1:0]       dist_cm;
    logic [DLT_W-1:0]        dlt;
  } pair_t;

  typedef struct packed {
    logic              st;
    logic [DIST_W-1:0] dist_cm;
    logic [DLT_W-1:0]  dlt;
  } dist_res_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic signed [LAT_W-1:0] in_src_lat, in_tar_lat;
  logic signed [LON_W-1:0] in_src_lon, in_tar_lon;
  logic [ACC_W-1:0] in_src_accuracy, in_tar_accuracy;
  logic in_src_valid, in_tar_valid;
  logic cfg_valid, cfg_ready;
  logic [RAD_W-1:0] cfg_data;
  logic out_valid, out_stall, out_status;
  logic [DIST_W-1:0] out_distance_cm;
  logic [DLT_W-1:0] out_delta_cm;

  great_circle_distance_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_src_lat(in_src_lat), .in_src_lon(in_src_lon),
    .in_src_accuracy(in_src_accuracy), .in_src_valid(in_src_valid),
    .in_tar_lat(in_tar_lat), .in_tar_lon(in_tar_lon),
    .in_tar_accuracy(in_tar_accuracy), .in_tar_valid(in_tar_valid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_distance_cm(out_distance_cm), .out_delta_cm(out_delta_cm)
  );

  dist_res_t pending_results[$];
  logic [63:0] radius_m;
  int errors, n_checked, n_arg_err, n_sat;
  int send_idle_pct, stall_pct;
  bit pressure_req;

  // ---------------------------------------------------------------- predictor
  function automatic longint atan_step(int i);
    longint s, t;
    int k, e;
    s = 0;
    if (i == 0) return longint'(PI_Q60 >> 2);
    for (k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e > 60) break;
      t = longint'((64'd1 << (60 - e)) / (2 * k + 1));
      s += (k % 2) ? -t : t;
    end
    return s;
  endfunction

  function automatic logic [63:0] round_q60(logic [127:0] p);
    logic [127:0] q;
    q = p + (128'd1 << 59);
    return q[123:60];
  endfunction

  function automatic longint mul_q60(longint a, longint b);
    logic [63:0] ua, ub, r;
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    r = round_q60({64'd0, ua} * {64'd0, ub}) & 64'h7FFFFFFFFFFFFFFF;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  task automatic sin_cos_q60(input longint d, output longint c, output longint s);
    longint r, x, y, z, xn, dx, dy;
    logic [63:0] m, rad;
    bit neg;
    int i;
    neg = 0;
    r = d % L360;
    if (r >= L180) r -= L360;
    if (r < -L180) r += L360;
    if (r > L90) begin
      r -= L180; neg = 1;
    end else if (r < -L90) begin
      r += L180; neg = 1;
    end
    m = (r < 0) ? 64'(-r) : 64'(r);
    rad = m * (PI_Q60 / 64'd1800000000)
        + (m * (PI_Q60 % 64'd1800000000) + 64'd900000000) / 64'd1800000000;
    z = (r < 0) ? -longint'(rad) : longint'(rad);
    x = K_Q60;
    y = 0;
    for (i = 0; i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    // fold the leftover angle in once
    xn = x - mul_q60(z, y);
    y = y + mul_q60(z, x);
    x = xn;
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint acos_q60(longint c);
    longint x, y, z, a, dx, dy;
    int i;
    x = longint'(int_sqrt(64'(ONE_Q60 + c))) << 30;
    y = longint'(int_sqrt(64'(ONE_Q60 - c))) << 30;
    z = 0;
    for (i = 0; i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    a = 2 * z;
    if (a < 0) a = 0;
    if (a > longint'(PI_Q60)) a = longint'(PI_Q60);
    return a;
  endfunction

  task automatic predict_distance(input pair_t p, output dist_res_t r);
    longint ca, sa, cb, sb, cd, sd, c, alpha;
    logic [63:0] d;
    r = '0;
    if (!p.sval || !p.tval) begin
      r.st = STATUS_ARG_ERR;
      return;
    end
    r.st = STATUS_OK;
    r.dlt = DLT_W'(p.sacc) + DLT_W'(p.tacc);
    if (p.slat == p.tlat && p.slon == p.tlon) return;
    sin_cos_q60(longint'(p.slat), ca, sa);
    sin_cos_q60(longint'(p.tlat), cb, sb);
    sin_cos_q60(longint'(p.tlon) - longint'(p.slon), cd, sd);
    c = mul_q60(sa, sb) + mul_q60(mul_q60(ca, cb), cd);
    if (c > ONE_Q60) c = ONE_Q60;
    if (c < -ONE_Q60) c = -ONE_Q60;
    alpha = acos_q60(c);
    d = round_q60({64'd0, 64'(alpha)} * {64'd0, radius_m * 64'd100});
    if (d > 64'h7FFFFFFF) d = 64'h7FFFFFFF;
    r.dist_cm = d[DIST_W-1:0];
  endtask

  // ------------------------------------------------------------- clock, reset
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------- receiver
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (pressure_req) begin
        hold_left = HOLD_CYCLES;
        pressure_req = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    dist_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result item with nothing expected: st=%0d dist=%0d dlt=%0d",
                 $time, out_status, out_distance_cm, out_delta_cm);
        errors++;
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (e.st == STATUS_ARG_ERR) n_arg_err++;
        if (e.dist_cm == 31'h7FFFFFFF) n_sat++;
        if (out_status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, out_status);
          errors++;
        end
        if (out_distance_cm !== e.dist_cm) begin
          $display("%0t: distance_cm expected %0d actual %0d",
                   $time, e.dist_cm, out_distance_cm);
          errors++;
        end
        if (out_delta_cm !== e.dlt) begin
          $display("%0t: delta_cm expected %0d actual %0d",
                   $time, e.dlt, out_delta_cm);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------- watchdog
  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) quiet = 0;
    else quiet++;
    if (quiet >= WDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WDOG_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sender
  task automatic send_pair(input pair_t p);
    dist_res_t r;
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(4, 1);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_src_lat <= p.slat; in_src_lon <= p.slon;
    in_src_accuracy <= p.sacc; in_src_valid <= p.sval;
    in_tar_lat <= p.tlat; in_tar_lon <= p.tlon;
    in_tar_accuracy <= p.tacc; in_tar_valid <= p.tval;
    do @(posedge clk); while (in_stall);
    predict_distance(p, r);
    if (p.typed && r != {p.st, p.dist_cm, p.dlt}) begin
      $display("%0t: typed row disagrees with predictor: typed %0h predicted %0h",
               $time, {p.st, p.dist_cm, p.dlt}, r);
      errors++;
    end
    pending_results.push_back(p.typed ? dist_res_t'({p.st, p.dist_cm, p.dlt}) : r);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  task automatic write_radius(input logic [RAD_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    radius_m = 64'(v);
  endtask

  function automatic pair_t random_pair();
    pair_t p;
    int sel;
    p = '0;
    p.slat = ($urandom_range(99) < 85) ? LAT_W'(longint'($urandom_range(1800000000, 0)) - L90)
                                       : LAT_W'($urandom);
    p.tlat = ($urandom_range(99) < 85) ? LAT_W'(longint'($urandom_range(1800000000, 0)) - L90)
                                       : LAT_W'($urandom);
    p.slon = ($urandom_range(99) < 85)
           ? LON_W'(longint'($urandom_range(32'd3600000000, 0)) - L180) : LON_W'($urandom);
    p.tlon = ($urandom_range(99) < 85)
           ? LON_W'(longint'($urandom_range(32'd3600000000, 0)) - L180) : LON_W'($urandom);
    p.sacc = ($urandom_range(99) < 80) ? ACC_W'($urandom_range(AMAX, 0)) : ACC_W'($urandom);
    p.tacc = ($urandom_range(99) < 80) ? ACC_W'($urandom_range(AMAX, 0)) : ACC_W'($urandom);
    p.sval = ($urandom_range(99) < 93);
    p.tval = ($urandom_range(99) < 93);
    sel = $urandom_range(99);
    if (sel < 5) begin
      p.tlat = p.slat; p.tlon = p.slon;
    end else if (sel < 15) begin
      // nearby points: short distances
      p.tlat = p.slat + LAT_W'($urandom_range(2000, 0)) - 1000;
      p.tlon = p.slon + LON_W'($urandom_range(2000, 0)) - 1000;
    end
    return p;
  endfunction

  // ------------------------------------------------------------------ main
  pair_t dir_rows [18];

  initial begin : main
    int i, ph;
    logic [RAD_W-1:0] radii [5];
    int send_mix [5];
    int stall_mix [5];
    errors = 0; n_checked = 0; n_arg_err = 0; n_sat = 0;
    send_idle_pct = 0; stall_pct = 0; pressure_req = 0;
    radius_m = 64'd6371010;
    rst_n = 0; in_valid = 0; cfg_valid = 0; cfg_data = '0;
    in_src_lat = '0; in_src_lon = '0; in_src_accuracy = '0; in_src_valid = 0;
    in_tar_lat = '0; in_tar_lon = '0; in_tar_accuracy = '0; in_tar_valid = 0;

    //            slat  slon  sacc  sv  tlat  tlon  tacc  tv typed st dist_cm dlt
    dir_rows[0]  = '{0, 0, 0, 1, 0, 0, 0, 1, 1, STATUS_OK, 0, 0};
    dir_rows[1]  = '{L90, L180, AMAX, 1, L90, L180, AMAX, 1, 1, STATUS_OK, 0, 200000000};
    dir_rows[2]  = '{-L90, -L180, 27'h7FFFFFF, 1, -L90, -L180, 27'h7FFFFFF, 1,
                     1, STATUS_OK, 0, 268435454};
    dir_rows[3]  = '{123, 456, 789, 0, 5, 6, 7, 1, 1, STATUS_ARG_ERR, 0, 0};
    dir_rows[4]  = '{123, 456, 789, 1, 5, 6, 7, 0, 1, STATUS_ARG_ERR, 0, 0};
    dir_rows[5]  = '{-1, -1, 27'h7FFFFFF, 0, -1, -1, 27'h7FFFFFF, 0,
                     1, STATUS_ARG_ERR, 0, 0};
    dir_rows[6]  = '{0, 0, 5, 1, 0, L180, 7, 1, 0, 0, 0, 0};
    dir_rows[7]  = '{0, L180, 1, 1, 0, -L180, 1, 1, 0, 0, 0, 0};
    dir_rows[8]  = '{L90, 0, 0, 1, -L90, 0, 0, 1, 0, 0, 0, 0};
    dir_rows[9]  = '{0, 0, 0, 1, 0, 1, 0, 1, 0, 0, 0, 0};
    dir_rows[10] = '{0, -L180, 3, 1, 0, L180 - 1, 4, 1, 0, 0, 0, 0};
    dir_rows[11] = '{31'sh3FFFFFFF, 0, 0, 1, -31'sh40000000, 0, 0, 1, 0, 0, 0, 0};
    dir_rows[12] = '{0, 32'sh7FFFFFFF, 0, 1, 0, -32'sh80000000, 0, 1, 0, 0, 0, 0};
    dir_rows[13] = '{L90, 0, 9, 1, L90, L180, 9, 1, 0, 0, 0, 0};
    dir_rows[14] = '{-L90, 123, 0, 1, -L90, -456, 0, 1, 0, 0, 0, 0};
    dir_rows[15] = '{450000000, 100, 0, 1, -450000000, -1700000000, 0, 1, 0, 0, 0, 0};
    dir_rows[16] = '{1, 1, 0, 1, 2, 2, 0, 1, 0, 0, 0, 0};
    dir_rows[17] = '{0, L90, AMAX, 1, 0, -L90, 0, 1, 0, 0, 0, 0};

    radii = '{23'd6300000, 23'd6400000, 23'(6300000 + $urandom_range(100000, 0)),
              23'h7FFFFF, 23'd6371010};
    send_mix  = '{0, 45, 0, 38, 38};
    stall_mix = '{0, 0, 45, 38, 38};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 18; i++) send_pair(dir_rows[i]);
    drain_pipe();

    for (ph = 0; ph < 5; ph++) begin
      write_radius(radii[ph]);
      send_idle_pct = send_mix[ph];
      stall_pct = stall_mix[ph];
      // long receiver hold while items keep coming: fill the pipeline
      if (ph == 0) pressure_req = 1;
      for (i = 0; i < 300; i++) send_pair(random_pair());
      drain_pipe();
      send_idle_pct = 0;
      stall_pct = 0;
    end

    $display("checked %0d result items over five radius settings", n_checked);
    $display("  %0d argument errors, %0d saturated distances", n_arg_err, n_sat);
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/gcd_pkg.sv
design/gcd_delay.sv
design/gcd_mul.sv
design/gcd_cordic_cell.sv
design/gcd_sqrt_cell.sv
design/gcd_sincos.sv
design/great_circle_distance_unit.sv
test/tb_top.sv
